// File: src/mhpq_pkg.sv
// Shared constants for the max-heap priority queue: command and status codes, port widths.
package mhpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: src/max_heap_priority_queue.sv
// Binary max-heap priority queue with one single-port key memory and a sift sequencer.
//
// Input channel (i_valid/o_stall) carries a command and a signed key. Insert puts the
// key in the first free slot and sifts it up; remove takes the root out, moves the last
// entry to the root and sifts it down. Every input beat gives exactly one output beat
// (o_valid/i_stall) with the removed key, the new top key, the entry count (mod 256)
// and a status: ok, remove on empty, insert on full.
// One item is worked on at a time; o_stall is high from acceptance until the result is
// loaded into the output register, and the next beat can be taken the cycle after. Each
// step of a sift up does one read of the key memory (the parent) and each step of a
// sift down two (the left and the right child), so the memory port sets the pace. An
// insert reads and compares the parent per level climbed; a remove reads the root,
// then the last entry, then per level the two children; every item ends with a read
// of the new top key. Error beats go straight to that read.
// A finished result sits in the output register while i_stall is high; the next item
// may be accepted meanwhile and waits in its last state until the register is free.
// Reset empties the heap and drops any pending beat; the memory needs no clearing,
// since only slots below the fill count are ever used.
module max_heap_priority_queue #(
    parameter int CAPACITY  = 128,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mhpq_pkg::VALUE_W-1:0] o_removed_value,
    output logic signed [mhpq_pkg::VALUE_W-1:0] o_top_value,
    output logic [mhpq_pkg::COUNT_W-1:0]        o_entry_count,
    output logic [mhpq_pkg::STATUS_W-1:0]       o_status
);

    localparam int SW = (KEY_WIDTH < mhpq_pkg::VALUE_W) ? KEY_WIDTH : mhpq_pkg::VALUE_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_RD   = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_RM_LAST = 4'd3;
    localparam logic [3:0] S_RM_KEY  = 4'd4;
    localparam logic [3:0] S_DN_RDL  = 4'd5;
    localparam logic [3:0] S_DN_RDR  = 4'd6;
    localparam logic [3:0] S_DN_CMP  = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;
    localparam logic [3:0] S_TOP     = 4'd9;

    logic signed [SW-1:0] mem [CAPACITY];

    logic [3:0]                     r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_hole, n_hole;
    logic signed [SW-1:0]           r_key, n_key;
    logic signed [SW-1:0]           r_left, n_left;
    logic                           r_has_r, n_has_r;
    logic signed [SW-1:0]           r_removed, n_removed;
    logic [mhpq_pkg::STATUS_W-1:0]  r_status, n_status;
    logic signed [SW-1:0]           r_rdata;

    logic                           r_ov, n_ov;
    logic signed [mhpq_pkg::VALUE_W-1:0] r_o_removed, n_o_removed;
    logic signed [mhpq_pkg::VALUE_W-1:0] r_o_top, n_o_top;
    logic [mhpq_pkg::COUNT_W-1:0]   r_o_cnt, n_o_cnt;
    logic [mhpq_pkg::STATUS_W-1:0]  r_o_status, n_o_status;

    logic                           mem_we, mem_re;
    logic [AW-1:0]                  waddr, raddr;
    logic signed [SW-1:0]           wdata;
    logic [CW:0]                    lidx, ridx;
    logic                           pick_r;
    logic signed [SW-1:0]           big;
    logic                           accept;

    assign accept = i_valid && !o_stall;
    assign lidx   = {r_hole, 1'b0};
    assign ridx   = lidx + (CW+1)'(1);
    assign pick_r = r_has_r && (r_left < r_rdata);
    assign big    = pick_r ? r_rdata : r_left;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_hole      = r_hole;
        n_key       = r_key;
        n_left      = r_left;
        n_has_r     = r_has_r;
        n_removed   = r_removed;
        n_status    = r_status;
        n_ov        = r_ov && i_stall;
        n_o_removed = r_o_removed;
        n_o_top     = r_o_top;
        n_o_cnt     = r_o_cnt;
        n_o_status  = r_o_status;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        waddr       = AW'(r_hole - CW'(1));
        wdata       = r_key;
        raddr       = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_removed = '0;
                    n_status  = mhpq_pkg::ST_OK;
                    if (i_cmd == mhpq_pkg::CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_hole  = r_count + CW'(1);
                            n_key   = SW'(i_value);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            mem_re  = 1'b1;
                            raddr   = '0;
                            n_state = S_RM_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_hole == CW'(1)) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    raddr   = AW'((r_hole >> 1) - CW'(1));
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_rdata < r_key) begin
                    wdata   = r_rdata;
                    n_hole  = r_hole >> 1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RM_LAST: begin
                n_removed = r_rdata;
                mem_re    = 1'b1;
                raddr     = AW'(r_count - CW'(1));
                n_state   = S_RM_KEY;
            end
            S_RM_KEY: begin
                n_key   = r_rdata;
                n_count = r_count - CW'(1);
                n_hole  = CW'(1);
                n_state = S_DN_RDL;
            end
            S_DN_RDL: begin
                if (lidx > {1'b0, r_count}) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    raddr   = AW'(lidx - (CW+1)'(1));
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_left  = r_rdata;
                n_has_r = ridx <= {1'b0, r_count};
                mem_re  = n_has_r;
                raddr   = AW'(ridx - (CW+1)'(1));
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (r_key < big) begin
                    wdata   = big;
                    n_hole  = CW'(lidx + (CW+1)'(pick_r));
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                mem_re  = 1'b1;
                raddr   = '0;
                n_state = S_TOP;
            end
            S_TOP: begin
                if (!r_ov || !i_stall) begin
                    n_ov        = 1'b1;
                    n_o_removed = mhpq_pkg::VALUE_W'(r_removed);
                    n_o_top     = (r_count == '0) ? '0 : mhpq_pkg::VALUE_W'(r_rdata);
                    n_o_cnt     = mhpq_pkg::COUNT_W'(r_count);
                    n_o_status  = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole      <= n_hole;
        r_key       <= n_key;
        r_left      <= n_left;
        r_has_r     <= n_has_r;
        r_removed   <= n_removed;
        r_status    <= n_status;
        r_o_removed <= n_o_removed;
        r_o_top     <= n_o_top;
        r_o_cnt     <= n_o_cnt;
        r_o_status  <= n_o_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[raddr];
        end
    end

    assign o_stall         = r_state != S_IDLE;
    assign o_valid         = r_ov;
    assign o_removed_value = r_o_removed;
    assign o_top_value     = r_o_top;
    assign o_entry_count   = r_o_cnt;
    assign o_status        = r_o_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted beat did not start work");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == mhpq_pkg::ST_EMPTY |-> o_removed_value == '0
            && o_top_value == '0)
        else $error("remove on empty gave a key");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == mhpq_pkg::ST_FULL |->
            o_entry_count == mhpq_pkg::COUNT_W'(CAPACITY))
        else $error("insert on full with room left");

endmodule

// File: tb/mhpq_checker.sv
// Checker for the max-heap priority queue: keeps a shadow heap and compares each output beat.
module mhpq_checker #(
    parameter int CAPACITY = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_cmd,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] i_removed_value,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] i_top_value,
    input  logic [mhpq_pkg::COUNT_W-1:0]        i_entry_count,
    input  logic [mhpq_pkg::STATUS_W-1:0]       i_status,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic signed [mhpq_pkg::VALUE_W-1:0] removed;
        logic signed [mhpq_pkg::VALUE_W-1:0] top;
        logic [mhpq_pkg::COUNT_W-1:0]        count;
        logic [mhpq_pkg::STATUS_W-1:0]       status;
    } t_heap_result;

    logic signed [mhpq_pkg::VALUE_W-1:0] keys [1:CAPACITY];
    int                                  fill;
    t_heap_result                        awaited_results [$];
    int                                  fails;

    function automatic t_heap_result heap_apply(input logic cmd,
                                                input logic signed [mhpq_pkg::VALUE_W-1:0] value);
        t_heap_result                        res;
        int                                  slot;
        int                                  big;
        bit                                  settled;
        logic signed [mhpq_pkg::VALUE_W-1:0] tmp;
        res = '0;
        res.status = mhpq_pkg::ST_OK;
        if (cmd == mhpq_pkg::CMD_INSERT) begin
            if (fill >= CAPACITY) begin
                res.status = mhpq_pkg::ST_FULL;
            end else begin
                fill++;
                keys[fill] = value;
                slot = fill;
                while (slot > 1 && keys[slot / 2] < keys[slot]) begin
                    tmp = keys[slot / 2];
                    keys[slot / 2] = keys[slot];
                    keys[slot] = tmp;
                    slot = slot / 2;
                end
            end
        end else if (fill == 0) begin
            res.status = mhpq_pkg::ST_EMPTY;
        end else begin
            res.removed = keys[1];
            keys[1] = keys[fill];
            fill--;
            slot = 1;
            settled = 1'b0;
            while (!settled) begin
                big = slot;
                if (2 * slot <= fill && keys[big] < keys[2 * slot])
                    big = 2 * slot;
                if (2 * slot + 1 <= fill && keys[big] < keys[2 * slot + 1])
                    big = 2 * slot + 1;
                if (big == slot) begin
                    settled = 1'b1;
                end else begin
                    tmp = keys[big];
                    keys[big] = keys[slot];
                    keys[slot] = tmp;
                    slot = big;
                end
            end
        end
        res.top = (fill > 0) ? keys[1] : '0;
        res.count = fill[mhpq_pkg::COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result want;
        bit           bad;
        if (!i_rst_n) begin
            fill = 0;
            fails = 0;
            awaited_results.delete();
        end else begin
            // output side first: a beat leaving now belongs to an older item
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected beat: removed=%0d top=%0d count=%0d status=%0d",
                                 i_removed_value, i_top_value, i_entry_count, i_status);
                end else begin
                    want = awaited_results.pop_front();
                    bad = (i_removed_value !== want.removed) || (i_top_value !== want.top) ||
                          (i_entry_count !== want.count) || (i_status !== want.status);
                    if (bad) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: removed %0d/%0d top %0d/%0d count %0d/%0d %s",
                                     want.removed, i_removed_value, want.top, i_top_value,
                                     want.count, i_entry_count,
                                     $sformatf("status %0d/%0d (expected/actual)",
                                               want.status, i_status));
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(heap_apply(i_cmd, i_value));
        end
        o_fail_count <= fails;
        o_pending <= awaited_results.size();
    end

endmodule

// File: tb/max_heap_priority_queue_test.sv
// Top of the max-heap priority queue testbench: clock, reset, stimulus phases and verdict.
module max_heap_priority_queue_test;

    localparam int HEAP_DEPTH      = 128;
    localparam int ITEMS_PER_PHASE = 207;
    localparam int CYCLE_LIMIT     = 300000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic                                i_cmd;
    logic signed [mhpq_pkg::VALUE_W-1:0] i_value;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [mhpq_pkg::VALUE_W-1:0] o_removed_value;
    logic signed [mhpq_pkg::VALUE_W-1:0] o_top_value;
    logic [mhpq_pkg::COUNT_W-1:0]        o_entry_count;
    logic [mhpq_pkg::STATUS_W-1:0]       o_status;

    int fail_count;
    int pending;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycles;
    int level;

    max_heap_priority_queue #(
        .CAPACITY  (HEAP_DEPTH),
        .KEY_WIDTH (mhpq_pkg::VALUE_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_removed_value (o_removed_value),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

    mhpq_checker #(
        .CAPACITY (HEAP_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_removed_value (o_removed_value),
        .i_top_value     (o_top_value),
        .i_entry_count   (o_entry_count),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // one input beat, held until taken
    task automatic send_request(input logic cmd,
                                input logic signed [mhpq_pkg::VALUE_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (cmd == mhpq_pkg::CMD_INSERT && level < HEAP_DEPTH)
            level++;
        else if (cmd == mhpq_pkg::CMD_REMOVE && level > 0)
            level--;
    endtask

    initial begin
        logic                                climbing;
        int                                  edge_hits;
        logic                                cmd;
        logic signed [mhpq_pkg::VALUE_W-1:0] value;
        level              = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd   <= mhpq_pkg::CMD_INSERT;
        i_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty remove, key extremes, ties on both sift directions
        send_request(mhpq_pkg::CMD_REMOVE, 32'sd0);
        send_request(mhpq_pkg::CMD_INSERT, 32'sh7fffffff);
        send_request(mhpq_pkg::CMD_INSERT, 32'sh80000000);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd0);
        send_request(mhpq_pkg::CMD_INSERT, -32'sd1);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd5);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd5);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd5);
        send_request(mhpq_pkg::CMD_INSERT, -32'sd5);
        repeat (9) send_request(mhpq_pkg::CMD_REMOVE, 32'shffffffff);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd9);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd4);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd4);
        repeat (3) send_request(mhpq_pkg::CMD_REMOVE, 32'sd0);

        climbing  = 1'b1;
        edge_hits = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
                default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                // sweep full to empty and back, pushing past each end a few times
                if (climbing && level == HEAP_DEPTH)
                    cmd = mhpq_pkg::CMD_INSERT;
                else if (!climbing && level == 0)
                    cmd = mhpq_pkg::CMD_REMOVE;
                else if (climbing)
                    cmd = ($urandom_range(99) < 80) ? mhpq_pkg::CMD_INSERT
                                                    : mhpq_pkg::CMD_REMOVE;
                else
                    cmd = ($urandom_range(99) < 20) ? mhpq_pkg::CMD_INSERT
                                                    : mhpq_pkg::CMD_REMOVE;
                if ((climbing && level == HEAP_DEPTH) || (!climbing && level == 0))
                    edge_hits++;
                if (edge_hits >= 3) begin
                    climbing  = !climbing;
                    edge_hits = 0;
                end
                case ($urandom_range(9))
                    0:       value = 32'sh7fffffff;
                    1:       value = 32'sh80000000;
                    2:       value = 32'sd0;
                    3:       value = -32'sd1;
                    4, 5:    value = $signed($urandom_range(8)) - 32'sd4;
                    default: value = $urandom;
                endcase
                send_request(cmd, value);
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/mhpq_pkg.sv
src/max_heap_priority_queue.sv
tb/mhpq_checker.sv
tb/max_heap_priority_queue_test.sv
